// ===== design/stdq_pkg.sv =====
// Shared types and constants for the sorted deadline timer queue.
`default_nettype none

package stdq_pkg;

  localparam int DEPTH       = 32;
  localparam int HANDLE_BITS = 16;
  localparam int HANDLE_W    = 16;
  localparam int TIME_W      = 32;
  localparam int OCC_W       = 6;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_ADJUST = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_DUP      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_EXEC     = 3'd1,
    S_ADJ_INS  = 3'd2,
    S_TICK_CNT = 3'd3,
    S_TICK_OUT = 3'd4
  } state_t;

  typedef struct packed {
    logic                   valid;
    logic [HANDLE_BITS-1:0] handle;
    logic [TIME_W-1:0]      deadline;
  } entry_t;

  typedef struct packed {
    cell_op_t               op;
    logic [HANDLE_BITS-1:0] handle;
    logic [TIME_W-1:0]      key;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/stdq_cell.sv =====
// One slot of the sorted timer chain, shifting entries to and from its neighbors.
`default_nettype none

module stdq_cell
  import stdq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_cmd_t cmd,
  input  wire entry_t    prev_entry,
  input  wire logic      prev_after,
  input  wire entry_t    next_entry,
  input  wire logic      remove_here,
  output entry_t         entry,
  output logic           after,
  output logic           match
);

  entry_t entry_next;

  // A slot lies after the insertion point when it is empty or its deadline is later.
  assign after = !(entry.valid && (entry.deadline <= cmd.key));
  assign match = entry.valid && (entry.handle == cmd.handle);

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      CELL_INSERT: begin
        if (after) begin
          if (prev_after) begin
            entry_next = prev_entry;
          end else begin
            entry_next.valid    = 1'b1;
            entry_next.handle   = cmd.handle;
            entry_next.deadline = cmd.key;
          end
        end
      end
      CELL_REMOVE: begin
        if (remove_here) begin
          entry_next = next_entry;
        end
      end
      CELL_POP: begin
        entry_next = next_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/sorted_deadline_timer_queue_unit.sv =====
// Top level of the sorted deadline timer queue: command control over a chain of slots.
//
// A command word is taken when start is high and busy is low: action, handle,
// expire_time (add, adjust) and now_time (tick). Results come back one word per
// cycle on status, expired_valid, expired_handle, occupancy and last, each marked
// by a one-cycle strobe; last flags the final word of a command. The receiver
// cannot stall, so every result word is shown exactly once.
// Timers sit in a row of slots kept in deadline order; every slot compares
// itself with the command key in the same cycle and shifts toward its neighbor.
// Add and delete, and an adjust whose handle is not found, give their result word
// from the execute state; a found adjust is removed there and reinserted in S_ADJ_INS,
// which gives its word. A tick first counts the expired timers, then hands out one
// expired timer per cycle from the front of the row, one word each; a tick with none expired gives one word.
// busy drops as the final word is registered, so the next command can be taken
// while that word is shown. Synchronous reset empties the queue at once.
`default_nettype none

module sorted_deadline_timer_queue_unit
  import stdq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          action,
  input  wire logic [HANDLE_W-1:0] handle,
  input  wire logic [TIME_W-1:0]   expire_time,
  input  wire logic [TIME_W-1:0]   now_time,
  output logic                     strobe,
  output logic [1:0]               status,
  output logic                     expired_valid,
  output logic [HANDLE_W-1:0]      expired_handle,
  output logic [OCC_W-1:0]         occupancy,
  output logic                     last
);

  localparam logic [DEPTH-1:0] ONES = {DEPTH{1'b1}};

  state_t                 state, state_next;
  action_t                act;
  logic [HANDLE_BITS-1:0] key_handle;
  logic [TIME_W-1:0]      key_time;
  logic [CNT_W-1:0]       count, count_next;
  logic [CNT_W-1:0]       tick_left, tick_left_next;
  logic [CNT_W-1:0]       tick_n;

  cell_op_t               op;
  cell_cmd_t              cmd;
  entry_t                 cell_entry [DEPTH];
  logic [DEPTH-1:0]       cell_after;
  logic [DEPTH-1:0]       cell_match;
  logic [DEPTH-1:0]       remove_from;
  logic [DEPTH:0]         expired_ext;
  logic                   found;

  logic                   strobe_next;
  status_t                status_next;
  logic                   exp_valid_next;
  logic [HANDLE_W-1:0]    exp_handle_next;
  logic [OCC_W-1:0]       occ_next;
  logic                   last_next;

  assign busy = (state != S_IDLE);
  assign cmd  = '{op: op, handle: key_handle, key: key_time};

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;
      logic   prev_a;
      if (gi == 0) begin : g_first
        assign prev_e = '0;
        assign prev_a = 1'b0;
      end else begin : g_mid
        assign prev_e = cell_entry[gi-1];
        assign prev_a = cell_after[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_end
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = cell_entry[gi+1];
      end
      stdq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .prev_entry  (prev_e),
        .prev_after  (prev_a),
        .next_entry  (next_e),
        .remove_here (remove_from[gi]),
        .entry       (cell_entry[gi]),
        .after       (cell_after[gi]),
        .match       (cell_match[gi])
      );
    end
  endgenerate

  assign found       = |cell_match;
  assign expired_ext = {1'b0, ~cell_after};

  // A slot pulls from its right neighbor when the matching slot is at or before it.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      remove_from[i] = |(cell_match & (ONES >> (DEPTH - 1 - i)));
    end
  end

  // The expired slots form a prefix; the edge of that prefix gives their number.
  always_comb begin
    tick_n = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (expired_ext[i] && !expired_ext[i+1]) begin
        tick_n = tick_n | CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (action_t'(action) == ACT_TICK) ? S_TICK_CNT : S_EXEC;
        end
      end
      S_EXEC: begin
        if ((act == ACT_ADJUST) && found) begin
          state_next = S_ADJ_INS;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ADJ_INS: begin
        state_next = S_IDLE;
      end
      S_TICK_CNT: begin
        state_next = (tick_n == '0) ? S_IDLE : S_TICK_OUT;
      end
      S_TICK_OUT: begin
        if (!expired_ext[1]) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    op              = CELL_HOLD;
    count_next      = count;
    tick_left_next  = tick_left;
    strobe_next     = 1'b0;
    status_next     = ST_OK;
    exp_valid_next  = 1'b0;
    exp_handle_next = '0;
    occ_next        = '0;
    last_next       = 1'b0;
    case (state)
      S_EXEC: begin
        if (act == ACT_ADD) begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          if (found) begin
            status_next = ST_DUP;
          end else if (count == CNT_W'(DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            op         = CELL_INSERT;
            count_next = count + 1'b1;
          end
          occ_next = OCC_W'(count_next);
        end else if (!found) begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          status_next = ST_NOTFOUND;
          occ_next    = OCC_W'(count);
        end else begin
          op         = CELL_REMOVE;
          count_next = count - 1'b1;
          if (act != ACT_ADJUST) begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
            occ_next    = OCC_W'(count_next);
          end
        end
      end
      S_ADJ_INS: begin
        op          = CELL_INSERT;
        count_next  = count + 1'b1;
        strobe_next = 1'b1;
        last_next   = 1'b1;
        occ_next    = OCC_W'(count_next);
      end
      S_TICK_CNT: begin
        tick_left_next = count - tick_n;
        if (tick_n == '0) begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          occ_next    = OCC_W'(count);
        end
      end
      S_TICK_OUT: begin
        op              = CELL_POP;
        count_next      = count - 1'b1;
        strobe_next     = 1'b1;
        exp_valid_next  = 1'b1;
        exp_handle_next = HANDLE_W'(cell_entry[0].handle);
        occ_next        = OCC_W'(tick_left);
        last_next       = !expired_ext[1];
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act        <= action_t'(action);
      key_handle <= handle[HANDLE_BITS-1:0];
      key_time   <= (action_t'(action) == ACT_TICK) ? now_time : expire_time;
    end
    tick_left      <= tick_left_next;
    status         <= status_next;
    expired_valid  <= exp_valid_next;
    expired_handle <= exp_handle_next;
    occupancy      <= occ_next;
    last           <= last_next;
  end

endmodule

`default_nettype wire

// ===== tb/sv/timer_queue_checker.sv =====
// Checker for the timer queue: predicts every result word and compares it with the block.
module timer_queue_checker
  import stdq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [1:0]          action,
  input  wire logic [HANDLE_W-1:0] handle,
  input  wire logic [TIME_W-1:0]   expire_time,
  input  wire logic [TIME_W-1:0]   now_time,
  input  wire logic                strobe,
  input  wire logic [1:0]          status,
  input  wire logic                expired_valid,
  input  wire logic [HANDLE_W-1:0] expired_handle,
  input  wire logic [OCC_W-1:0]    occupancy,
  input  wire logic                last,
  input  wire logic                sweep_done,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic [1:0]          status;
    logic                expired_valid;
    logic [HANDLE_W-1:0] expired_handle;
    logic [OCC_W-1:0]    occupancy;
    logic                last;
  } word_t;

  logic [HANDLE_W-1:0] row_handle [DEPTH];
  logic [TIME_W-1:0]   row_deadline [DEPTH];
  int unsigned         row_count = 0;
  word_t               due_words [$];

  int words_checked = 0;
  int timers_expired = 0;
  int peak_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit summary_done = 1'b0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $write("%0t: %s: got st=%0d exp_v=%0d exp_h=%h occ=%0d last=%0d, ",
           $time, what, got.status, got.expired_valid, got.expired_handle, got.occupancy,
           got.last);
    $display("want st=%0d exp_v=%0d exp_h=%h occ=%0d last=%0d",
             want.status, want.expired_valid, want.expired_handle, want.occupancy,
             want.last);
    fail_count++;
  endtask

  function automatic int find_timer(input logic [HANDLE_W-1:0] h);
    for (int i = 0; i < int'(row_count); i++) begin
      if (row_handle[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic void drop_timer(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < row_count; i++) begin
      row_handle[i] = row_handle[i + 1];
      row_deadline[i] = row_deadline[i + 1];
    end
    row_count--;
  endfunction

  // A timer goes after every timer whose deadline is not later than its own.
  function automatic void place_timer(input logic [HANDLE_W-1:0] h,
                                      input logic [TIME_W-1:0] dl);
    int unsigned pos;
    pos = 0;
    while (pos < row_count && row_deadline[pos] <= dl) pos++;
    for (int unsigned i = row_count; i > pos; i--) begin
      row_handle[i] = row_handle[i - 1];
      row_deadline[i] = row_deadline[i - 1];
    end
    row_handle[pos] = h;
    row_deadline[pos] = dl;
    row_count++;
  endfunction

  task automatic predict_command(input logic [1:0] act, input logic [HANDLE_W-1:0] h_in,
                                 input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] now);
    logic [HANDLE_W-1:0] h;
    logic [HANDLE_W-1:0] gone [$];
    logic [1:0]          st;
    int                  pos;
    word_t               w;
    h = '0;
    h[HANDLE_BITS-1:0] = h_in[HANDLE_BITS-1:0];
    st = ST_OK;
    if (act == ACT_TICK) begin
      while (row_count > 0 && row_deadline[0] <= now) begin
        gone.push_back(row_handle[0]);
        drop_timer(0);
      end
    end else begin
      pos = find_timer(h);
      case (act)
        ACT_ADD: begin
          if (pos >= 0) st = ST_DUP;
          else if (row_count >= DEPTH) st = ST_FULL;
          else place_timer(h, dl);
        end
        default: begin
          if (pos < 0) begin
            st = ST_NOTFOUND;
          end else begin
            drop_timer(pos);
            if (act == ACT_ADJUST) place_timer(h, dl);
          end
        end
      endcase
    end
    status_seen[st]++;
    timers_expired += gone.size();
    if (int'(row_count) > peak_count) peak_count = row_count;
    w.status = st;
    w.expired_valid = 1'b0;
    w.expired_handle = '0;
    w.occupancy = OCC_W'(row_count);
    w.last = 1'b1;
    if (gone.size() == 0) begin
      due_words.push_back(w);
    end else begin
      foreach (gone[k]) begin
        w.expired_valid = 1'b1;
        w.expired_handle = gone[k];
        w.last = (k == gone.size() - 1);
        due_words.push_back(w);
      end
    end
  endtask

  task automatic check_word();
    word_t got;
    word_t want;
    got.status = status;
    got.expired_valid = expired_valid;
    got.expired_handle = expired_handle;
    got.occupancy = occupancy;
    got.last = last;
    words_checked++;
    if (due_words.size() == 0) begin
      report_mismatch("word with nothing expected", got, '0);
    end else begin
      want = due_words.pop_front();
      if (got !== want) report_mismatch("wrong word", got, want);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      row_count = 0;
      due_words.delete();
    end else begin
      if (strobe) check_word();
      if (start && !busy) predict_command(action, handle, expire_time, now_time);
      if (sweep_done && !summary_done) begin
        summary_done = 1'b1;
        foreach (due_words[i]) report_mismatch("expected word never came", '0, due_words[i]);
        $display("Checked %0d result words; tick handed out %0d timers; peak occupancy %0d.",
                 words_checked, timers_expired, peak_count);
        $display("Status seen: ok %0d, full %0d, not found %0d, duplicate %0d.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOTFOUND],
                 status_seen[ST_DUP]);
      end
    end
    pending = due_words.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives command words into the timer queue and prints the verdict.
module tb;
  import stdq_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [1:0]          action = ACT_TICK;
  logic [HANDLE_W-1:0] handle = '0;
  logic [TIME_W-1:0]   expire_time = '0;
  logic [TIME_W-1:0]   now_time = '0;
  logic                busy;
  logic                strobe;
  logic [1:0]          status;
  logic                expired_valid;
  logic [HANDLE_W-1:0] expired_handle;
  logic [OCC_W-1:0]    occupancy;
  logic                last;
  logic                sweep_done = 1'b0;
  int                  fail_count;
  int                  pending;

  logic [HANDLE_W-1:0] handle_pool [40];
  logic [TIME_W-1:0]   clock_now;
  bit                  no_idle = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sorted_deadline_timer_queue_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .handle(handle),
    .expire_time(expire_time), .now_time(now_time), .strobe(strobe), .status(status),
    .expired_valid(expired_valid), .expired_handle(expired_handle), .occupancy(occupancy),
    .last(last)
  );

  timer_queue_checker words_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .handle(handle),
    .expire_time(expire_time), .now_time(now_time), .strobe(strobe), .status(status),
    .expired_valid(expired_valid), .expired_handle(expired_handle), .occupancy(occupancy),
    .last(last), .sweep_done(sweep_done), .fail_count(fail_count), .pending(pending)
  );

  // Holds start high until the block takes the word; start stays high across back-to-back words.
  task automatic send_word(input action_t act, input logic [HANDLE_W-1:0] h,
                           input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] now);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    handle <= h;
    expire_time <= dl;
    now_time <= now;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [HANDLE_W-1:0] pool_handle();
    if ($urandom_range(0, 9) == 0) return HANDLE_W'($urandom);
    return handle_pool[$urandom_range(0, 39)];
  endfunction

  function automatic logic [TIME_W-1:0] pick_deadline();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return $urandom;
    if (r == 1) return '1;
    return clock_now + $urandom_range(0, 60);
  endfunction

  initial begin
    int add_pct;
    int adj_pct;
    int del_pct;
    int pick;
    logic [TIME_W-1:0] now;
    clock_now = $urandom_range(0, 1000);
    foreach (handle_pool[i]) handle_pool[i] = HANDLE_W'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_word(ACT_TICK, HANDLE_W'($urandom), $urandom, '0);
    send_word(ACT_DELETE, 16'h0005, $urandom, $urandom);
    send_word(ACT_ADJUST, 16'h0005, 32'd7, $urandom);
    send_word(ACT_ADD, 16'h0000, '1, $urandom);
    send_word(ACT_ADD, 16'hFFFF, '0, $urandom);
    send_word(ACT_ADD, 16'h1234, 32'd100, $urandom);
    send_word(ACT_ADD, 16'h5678, 32'd100, $urandom);
    send_word(ACT_ADD, 16'h9ABC, 32'd100, $urandom);
    send_word(ACT_ADD, 16'h1234, 32'd5, $urandom);
    send_word(ACT_ADJUST, 16'h5678, 32'd100, $urandom);
    send_word(ACT_ADJUST, 16'h0000, 32'd50, $urandom);
    send_word(ACT_ADJUST, 16'hFFFF, 32'd200, $urandom);
    send_word(ACT_TICK, HANDLE_W'($urandom), $urandom, '0);
    send_word(ACT_TICK, HANDLE_W'($urandom), $urandom, 32'd100);
    send_word(ACT_DELETE, 16'hFFFF, $urandom, $urandom);
    send_word(ACT_DELETE, 16'hFFFF, $urandom, $urandom);
    send_word(ACT_TICK, HANDLE_W'($urandom), $urandom, '1);
    send_word(ACT_ADD, 16'hA5A5, '1, $urandom);
    send_word(ACT_TICK, HANDLE_W'($urandom), $urandom, '1);

    // Segments alternate between filling the store, mixed traffic and draining by ticks.
    for (int seg = 0; seg < 7; seg++) begin
      case (seg % 4)
        0: begin add_pct = 70; adj_pct = 80; del_pct = 85; end
        3: begin add_pct = 15; adj_pct = 30; del_pct = 50; end
        default: begin add_pct = 30; adj_pct = 55; del_pct = 75; end
      endcase
      for (int k = 0; k < 8; k++) handle_pool[$urandom_range(0, 39)] = HANDLE_W'($urandom);
      for (int n = 0; n < 50; n++) begin
        no_idle = (n >= 35);
        pick = $urandom_range(0, 99);
        if (pick < add_pct) begin
          send_word(ACT_ADD, pool_handle(), pick_deadline(), $urandom);
        end else if (pick < adj_pct) begin
          send_word(ACT_ADJUST, pool_handle(), pick_deadline(), $urandom);
        end else if (pick < del_pct) begin
          send_word(ACT_DELETE, pool_handle(), $urandom, $urandom);
        end else begin
          if ($urandom_range(0, 29) == 0) begin
            now = $urandom;
          end else begin
            clock_now = clock_now + $urandom_range(0, 12);
            now = clock_now;
          end
          send_word(ACT_TICK, HANDLE_W'($urandom), $urandom, now);
        end
      end
    end
    start <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    sweep_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/stdq_pkg.sv
design/stdq_cell.sv
design/sorted_deadline_timer_queue_unit.sv
tb/sv/timer_queue_checker.sv
tb/sv/tb.sv
